// ===== rtl/core/gcha_pkg.sv =====
// Package: shared constants and codes of the generation-checked handle allocator.
`default_nettype none

package gcha_pkg;

  // Default configuration
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned CHUNK_DEF    = 64;

  // Fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned GEN_W    = 31;
  localparam int unsigned LIVE_W   = 11;
  localparam int unsigned TAG_W    = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOK  = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FULL          = 4'd1;
  localparam logic [STATUS_W-1:0] ST_GEN_OVF       = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NULL          = 4'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE         = 4'd4;
  localparam logic [STATUS_W-1:0] ST_ALREADY       = 4'd5;
  localparam logic [STATUS_W-1:0] ST_WRONG         = 4'd6;
  localparam logic [STATUS_W-1:0] ST_UNINIT        = 4'd7;
  localparam logic [STATUS_W-1:0] ST_STALE         = 4'd8;
  localparam logic [STATUS_W-1:0] ST_FREE_UNINIT   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_FREE_MISMATCH = 4'd10;

  // Slot tag encoding: all-ones is free, bit 31 flags uninitialized
  localparam logic [TAG_W-1:0] TAG_FREE = 32'hFFFF_FFFF;
  localparam logic [GEN_W-1:0] GEN_LAST = 31'h7FFF_FFFE;

endpackage

`default_nettype wire

// ===== rtl/core/gcha_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module gcha_ram #(
  parameter int unsigned DEPTH = gcha_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = gcha_pkg::TAG_W,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/generation_checked_handle_allocator_unit.sv =====
// Top level: generational handle allocator with a FIFO free queue and chunked slot opening.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | operation_i, handle_index_i, handle_generation_i
//  out     | output    | out_valid_o/out_stall_i | status_o, result_index_o, result_generation_o,
//          |           |                      | live_total_o
//
// One item at a time. Initialize, lookup and free read the tag memory, then check and
// write back. Allocate decides, reads the free queue, then writes the tag.
// An allocate that finds every opened slot live first opens a chunk of up to CHUNK_SLOTS
// slots, one slot written to the tag and queue memories per cycle.
// Reset clears only the control state, pointers and counters; the memories need no clearing pass.
// A result waiting in the output register does not block the next transfer on the input;
// the commit of the following result waits while the output register stays stalled.
`default_nettype none

module generation_checked_handle_allocator_unit #(
  parameter int unsigned CAPACITY    = gcha_pkg::CAPACITY_DEF,
  parameter int unsigned CHUNK_SLOTS = gcha_pkg::CHUNK_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [gcha_pkg::OP_W-1:0]           operation_i,
  input  wire logic [gcha_pkg::HANDLE_W-1:0]       handle_index_i,
  input  wire logic [gcha_pkg::HANDLE_W-1:0]       handle_generation_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [gcha_pkg::STATUS_W-1:0]       status_o,
  output logic      [gcha_pkg::RIDX_W-1:0]         result_index_o,
  output logic      [gcha_pkg::GEN_W-1:0]          result_generation_o,
  output logic      [gcha_pkg::LIVE_W-1:0]         live_total_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ChW  = $clog2(CHUNK_SLOTS + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC  = 3'd1;
  localparam logic [2:0] S_OPEN   = 3'd2;
  localparam logic [2:0] S_AREAD  = 3'd3;
  localparam logic [2:0] S_ACCESS = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic [gcha_pkg::OP_W-1:0]        op_q, op_d;
  logic [gcha_pkg::HANDLE_W-1:0]    idx_q, idx_d;
  logic [gcha_pkg::HANDLE_W-1:0]    gen_q, gen_d;
  logic [IdxW-1:0]                  head_q, head_d;
  logic [IdxW-1:0]                  tail_q, tail_d;
  logic [CntW-1:0]                  opened_q, opened_d;
  logic [CntW-1:0]                  live_q, live_d;
  logic [gcha_pkg::GEN_W-1:0]       genctr_q, genctr_d;
  logic [ChW-1:0]                   chunk_q, chunk_d;

  logic                             out_valid_q, out_valid_d;
  logic [gcha_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [gcha_pkg::RIDX_W-1:0]      rindex_q, rindex_d;
  logic [gcha_pkg::GEN_W-1:0]       rgen_q, rgen_d;
  logic [gcha_pkg::LIVE_W-1:0]      rlive_q, rlive_d;

  // Memory ports
  logic                             tag_we, tag_re;
  logic [IdxW-1:0]                  tag_waddr;
  logic [gcha_pkg::TAG_W-1:0]       tag_wdata, tag_rdata;
  logic                             fq_we, fq_re;
  logic [IdxW-1:0]                  fq_waddr;
  logic [IdxW-1:0]                  fq_wdata, fq_rdata;

  logic                             out_free;
  logic                             null_hit, range_hit, store_full;
  logic [gcha_pkg::GEN_W-1:0]       gen_next;

  function automatic logic [IdxW-1:0] ptr_next(input logic [IdxW-1:0] p);
    return (p == IdxW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  gcha_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (gcha_pkg::TAG_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (tag_re),
    .raddr_i (handle_index_i[IdxW-1:0]),
    .rdata_o (tag_rdata)
  );

  gcha_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IdxW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (fq_we),
    .waddr_i (fq_waddr),
    .wdata_i (fq_wdata),
    .re_i    (fq_re),
    .raddr_i (head_q),
    .rdata_o (fq_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign gen_next   = genctr_q + 1'b1;

  // Handle checks on the captured item
  assign null_hit   = (op_q != gcha_pkg::OP_FREE) && (idx_q == '0) && (gen_q == '0);
  assign range_hit  = (idx_q >= gcha_pkg::HANDLE_W'(opened_q));
  assign store_full = (live_q >= opened_q) && (opened_q >= CntW'(CAPACITY));

  // Sequencer and read-modify-write
  always_comb begin
    logic [31:0] slot_ext;
    logic [31:0] live_ext;
    logic [gcha_pkg::STATUS_W-1:0] acc_st;

    slot_ext    = 32'(fq_rdata);
    live_ext    = '0;
    acc_st      = gcha_pkg::ST_OK;

    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    gen_d       = gen_q;
    head_d      = head_q;
    tail_d      = tail_q;
    opened_d    = opened_q;
    live_d      = live_q;
    genctr_d    = genctr_q;
    chunk_d     = chunk_q;

    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    rindex_d    = rindex_q;
    rgen_d      = rgen_q;
    rlive_d     = rlive_q;

    tag_we      = 1'b0;
    tag_re      = 1'b0;
    tag_waddr   = idx_q[IdxW-1:0];
    tag_wdata   = gcha_pkg::TAG_FREE;
    fq_we       = 1'b0;
    fq_re       = 1'b0;
    fq_waddr    = tail_q;
    fq_wdata    = idx_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = operation_i;
          idx_d = handle_index_i;
          gen_d = handle_generation_i;
          if (operation_i == gcha_pkg::OP_ALLOC) begin
            state_d = S_ALLOC;
          end else begin
            tag_re  = 1'b1;
            state_d = S_ACCESS;
          end
        end
      end

      S_ALLOC: begin
        if (store_full || genctr_q == gcha_pkg::GEN_LAST) begin
          if (out_free) begin
            live_ext    = 32'(live_q);
            out_valid_d = 1'b1;
            status_d    = store_full ? gcha_pkg::ST_FULL : gcha_pkg::ST_GEN_OVF;
            rindex_d    = '0;
            rgen_d      = '0;
            rlive_d     = live_ext[gcha_pkg::LIVE_W-1:0];
            state_d     = S_IDLE;
          end
        end else if (live_q >= opened_q) begin
          chunk_d = '0;
          state_d = S_OPEN;
        end else begin
          fq_re   = 1'b1;
          state_d = S_AREAD;
        end
      end

      // Open one slot per cycle: tag it free and queue it
      S_OPEN: begin
        if (chunk_q != ChW'(CHUNK_SLOTS) && opened_q != CntW'(CAPACITY)) begin
          tag_we    = 1'b1;
          tag_waddr = opened_q[IdxW-1:0];
          tag_wdata = gcha_pkg::TAG_FREE;
          fq_we     = 1'b1;
          fq_waddr  = tail_q;
          fq_wdata  = opened_q[IdxW-1:0];
          tail_d    = ptr_next(tail_q);
          opened_d  = opened_q + 1'b1;
          chunk_d   = chunk_q + 1'b1;
        end else begin
          state_d = S_ALLOC;
        end
      end

      // Queue head is valid: claim the slot
      S_AREAD: begin
        if (out_free) begin
          tag_we      = 1'b1;
          tag_waddr   = fq_rdata;
          tag_wdata   = {1'b1, gen_next};
          genctr_d    = gen_next;
          head_d      = ptr_next(head_q);
          live_d      = live_q + 1'b1;
          live_ext    = 32'(live_d);
          out_valid_d = 1'b1;
          status_d    = gcha_pkg::ST_OK;
          rindex_d    = slot_ext[gcha_pkg::RIDX_W-1:0];
          rgen_d      = gen_next;
          rlive_d     = live_ext[gcha_pkg::LIVE_W-1:0];
          state_d     = S_IDLE;
        end
      end

      // Tag is valid: check the handle and write back
      S_ACCESS: begin
        if (out_free) begin
          if (null_hit) begin
            acc_st = gcha_pkg::ST_NULL;
          end else if (range_hit) begin
            acc_st = gcha_pkg::ST_RANGE;
          end else begin
            unique case (op_q)
              gcha_pkg::OP_INIT: begin
                if (!tag_rdata[31]) begin
                  acc_st = gcha_pkg::ST_ALREADY;
                end else if (tag_rdata == gcha_pkg::TAG_FREE ||
                             {1'b0, tag_rdata[30:0]} != gen_q) begin
                  acc_st = gcha_pkg::ST_WRONG;
                end else begin
                  acc_st    = gcha_pkg::ST_OK;
                  tag_we    = 1'b1;
                  tag_wdata = {1'b0, tag_rdata[30:0]};
                end
              end
              gcha_pkg::OP_LOOK: begin
                if (!tag_rdata[31] && tag_rdata == gen_q) begin
                  acc_st = gcha_pkg::ST_OK;
                end else if (tag_rdata[31] && tag_rdata != gcha_pkg::TAG_FREE) begin
                  acc_st = gcha_pkg::ST_UNINIT;
                end else begin
                  acc_st = gcha_pkg::ST_STALE;
                end
              end
              gcha_pkg::OP_FREE: begin
                if (tag_rdata[31]) begin
                  acc_st = gcha_pkg::ST_FREE_UNINIT;
                end else if (tag_rdata != gen_q) begin
                  acc_st = gcha_pkg::ST_FREE_MISMATCH;
                end else begin
                  acc_st    = gcha_pkg::ST_OK;
                  tag_we    = 1'b1;
                  tag_wdata = gcha_pkg::TAG_FREE;
                  fq_we     = 1'b1;
                  tail_d    = ptr_next(tail_q);
                  if (live_q != '0) begin
                    live_d = live_q - 1'b1;
                  end
                end
              end
              default: begin
                acc_st = gcha_pkg::ST_OK;
              end
            endcase
          end
          live_ext    = 32'(live_d);
          out_valid_d = 1'b1;
          status_d    = acc_st;
          rindex_d    = idx_q[gcha_pkg::RIDX_W-1:0];
          rgen_d      = '0;
          rlive_d     = live_ext[gcha_pkg::LIVE_W-1:0];
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      opened_q    <= '0;
      live_q      <= '0;
      genctr_q    <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      opened_q    <= opened_d;
      live_q      <= live_d;
      genctr_q    <= genctr_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured item and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    gen_q    <= gen_d;
    status_q <= status_d;
    rindex_q <= rindex_d;
    rgen_q   <= rgen_d;
    rlive_q  <= rlive_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign result_index_o      = rindex_q;
  assign result_generation_o = rgen_q;
  assign live_total_o        = rlive_q;

endmodule

`default_nettype wire

// ===== rtl/core/gcha_checker.sv =====
// Port-level checker for the handle allocator, bound to the top level.
`default_nettype none

module gcha_props #(
  parameter int unsigned CAPACITY = gcha_pkg::CAPACITY_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [gcha_pkg::STATUS_W-1:0]   status_o,
  input wire logic [gcha_pkg::RIDX_W-1:0]     result_index_o,
  input wire logic [gcha_pkg::GEN_W-1:0]      result_generation_o,
  input wire logic [gcha_pkg::LIVE_W-1:0]     live_total_o
);

  // One item in flight: a transfer in always closes the input for the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after a transfer");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(result_index_o) && $stable(result_generation_o) && $stable(live_total_o)))
    else $error("stalled result changed");

  // A generation is reported only with an OK status
  a_gen_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != gcha_pkg::ST_OK) |-> (result_generation_o == '0))
    else $error("generation reported on a failed operation");

  // Full is reported only with every slot live
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == gcha_pkg::ST_FULL) |->
      (live_total_o == gcha_pkg::LIVE_W'(CAPACITY) && result_index_o == '0))
    else $error("full status with free slots");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= gcha_pkg::ST_FREE_MISMATCH))
    else $error("undefined status code");

endmodule

bind generation_checked_handle_allocator_unit gcha_props #(
  .CAPACITY (CAPACITY)
) u_gcha_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .status_o            (status_o),
  .result_index_o      (result_index_o),
  .result_generation_o (result_generation_o),
  .live_total_o        (live_total_o)
);

`default_nettype wire

// ===== sim/gcha_checker.sv =====
// Checker: predicts the allocator's results from the input channel and scores the output channel.
module gcha_checker
  import gcha_pkg::*;
#(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned CHUNK_SLOTS = CHUNK_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [HANDLE_W-1:0] handle_index_i,
  input  logic [HANDLE_W-1:0] handle_generation_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [RIDX_W-1:0]   result_index_i,
  input  logic [GEN_W-1:0]    result_generation_i,
  input  logic [LIVE_W-1:0]   live_total_i,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o,
  output int unsigned         checked_o,
  output logic [15:0]         status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   index;
    logic [GEN_W-1:0]    generation;
    logic [LIVE_W-1:0]   live;
  } outcome_t;

  // Shadow copy of the allocator state
  logic [TAG_W-1:0] slot_tag   [CAPACITY];
  int unsigned      free_slots [CAPACITY];
  int unsigned      free_rd;
  int unsigned      free_wr;
  int unsigned      opened;
  int unsigned      live_cnt;
  logic [GEN_W-1:0] gen_cnt;

  // Scoreboard
  outcome_t    expected_q [$];
  outcome_t    want;
  int unsigned n_mismatch;
  int unsigned n_checked;
  logic [15:0] seen;

  function automatic void push_free(int unsigned slot);
    free_slots[free_wr] = slot;
    free_wr = (free_wr + 1 >= CAPACITY) ? 0 : free_wr + 1;
  endfunction

  function automatic outcome_t predict_allocate();
    outcome_t    res;
    int unsigned slot;
    res = '0;
    if (live_cnt >= opened && opened >= CAPACITY) begin
      res.status = ST_FULL;
    end else if (gen_cnt == GEN_LAST) begin
      // generation space used up: refused from here on
      res.status = ST_GEN_OVF;
    end else begin
      // every opened slot is live: open the next chunk in index order
      if (live_cnt >= opened) begin
        for (int n = 0; n < CHUNK_SLOTS && opened < CAPACITY; n++) begin
          slot_tag[opened] = TAG_FREE;
          push_free(opened);
          opened++;
        end
      end
      gen_cnt = gen_cnt + 1'b1;
      slot    = free_slots[free_rd];
      free_rd = (free_rd + 1 >= CAPACITY) ? 0 : free_rd + 1;
      slot_tag[slot] = {1'b1, gen_cnt};
      live_cnt++;
      res.status     = ST_OK;
      res.index      = RIDX_W'(slot);
      res.generation = gen_cnt;
    end
    res.live = LIVE_W'(live_cnt);
    return res;
  endfunction

  function automatic outcome_t predict_access(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] idx,
                                              logic [HANDLE_W-1:0] hgen);
    outcome_t         res;
    logic [TAG_W-1:0] tag;
    res       = '0;
    res.index = idx[RIDX_W-1:0];
    if (op != OP_FREE && idx == '0 && hgen == '0) begin
      res.status = ST_NULL;
    end else if (idx >= opened) begin
      // full 32-bit index against the opened region
      res.status = ST_RANGE;
    end else begin
      tag = slot_tag[idx];
      case (op)
        OP_INIT: begin
          if (!tag[TAG_W-1]) begin
            res.status = ST_ALREADY;
          end else if (tag == TAG_FREE || {1'b0, tag[GEN_W-1:0]} != hgen) begin
            res.status = ST_WRONG;
          end else begin
            slot_tag[idx] = {1'b0, tag[GEN_W-1:0]};
            res.status    = ST_OK;
          end
        end
        OP_LOOK: begin
          // a flagged tag never matches, even against its raw value
          if (!tag[TAG_W-1] && tag == hgen) begin
            res.status = ST_OK;
          end else if (tag[TAG_W-1] && tag != TAG_FREE) begin
            res.status = ST_UNINIT;
          end else begin
            res.status = ST_STALE;
          end
        end
        default: begin
          // free
          if (tag[TAG_W-1]) begin
            res.status = ST_FREE_UNINIT;
          end else if (tag != hgen) begin
            res.status = ST_FREE_MISMATCH;
          end else begin
            slot_tag[idx] = TAG_FREE;
            if (live_cnt > 0) live_cnt--;
            push_free(idx);
            res.status = ST_OK;
          end
        end
      endcase
    end
    res.live = LIVE_W'(live_cnt);
    return res;
  endfunction

  function automatic void flag(string what, longint unsigned exp_val, longint unsigned got_val);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    end
  endfunction

  // Compare result transfers first, then predict the input transfer of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_rd    = 0;
      free_wr    = 0;
      opened     = 0;
      live_cnt   = 0;
      gen_cnt    = '0;
      n_mismatch = 0;
      n_checked  = 0;
      seen       = '0;
      expected_q.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
      status_seen_o <= '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          flag("result with nothing pending, status", 0, status_i);
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          seen[want.status] = 1'b1;
          if (status_i !== want.status) flag("status", want.status, status_i);
          if (result_index_i !== want.index) flag("result_index", want.index, result_index_i);
          if (result_generation_i !== want.generation) begin
            flag("result_generation", want.generation, result_generation_i);
          end
          if (live_total_i !== want.live) flag("live_total", want.live, live_total_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_ALLOC) begin
          expected_q.push_back(predict_allocate());
        end else begin
          expected_q.push_back(predict_access(operation_i, handle_index_i,
                                              handle_generation_i));
        end
      end
      mismatches_o  <= n_mismatch;
      outstanding_o <= expected_q.size();
      checked_o     <= n_checked;
      status_seen_o <= seen;
    end
  end

endmodule

// ===== sim/tb_generation_checked_handle_allocator_unit.sv =====
// Testbench top: clock, reset, stimulus and verdict for the generational handle allocator.
module tb_generation_checked_handle_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gcha_pkg::*;

  localparam int unsigned SLOTS    = CAPACITY_DEF;
  localparam int unsigned CHUNK    = CHUNK_DEF;
  localparam int unsigned POOL_MAX = 48;

  typedef enum int unsigned {HS_FRESH, HS_READY, HS_RETIRED} handle_stage_e;

  typedef struct {
    logic [RIDX_W-1:0] index;
    logic [GEN_W-1:0]  generation;
    handle_stage_e     stage;
  } handle_t;

  const logic [OP_W-1:0] ACCESS_OPS [3] = '{OP_INIT, OP_LOOK, OP_FREE};

  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation         = OP_ALLOC;
  logic [HANDLE_W-1:0] handle_index      = '0;
  logic [HANDLE_W-1:0] handle_generation = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [RIDX_W-1:0]   result_index;
  logic [GEN_W-1:0]    result_generation;
  logic [LIVE_W-1:0]   live_total;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  logic [15:0] seen;

  int unsigned cyc        = 0;
  int unsigned stall_left = 0;
  int unsigned n_sent     = 0;
  logic        quiet      = 1'b0;

  logic [OP_W-1:0] ops_in_flight [$];
  handle_t         pool [$];
  handle_t         fresh;

  generation_checked_handle_allocator_unit #(
    .CAPACITY    (SLOTS),
    .CHUNK_SLOTS (CHUNK)
  ) i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .operation_i         (operation),
    .handle_index_i      (handle_index),
    .handle_generation_i (handle_generation),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status),
    .result_index_o      (result_index),
    .result_generation_o (result_generation),
    .live_total_o        (live_total)
  );

  gcha_checker #(
    .CAPACITY    (SLOTS),
    .CHUNK_SLOTS (CHUNK)
  ) i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .operation_i         (operation),
    .handle_index_i      (handle_index),
    .handle_generation_i (handle_generation),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .status_i            (status),
    .result_index_i      (result_index),
    .result_generation_i (result_generation),
    .live_total_i        (live_total),
    .mismatches_o        (mismatches),
    .outstanding_o       (outstanding),
    .checked_o           (checked),
    .status_seen_o       (seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver stalls in random bursts, only while bit 8 of the cycle counter is set
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (cyc[8] && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Collect allocated handles; sampled at the falling edge, ahead of the transfer edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (ops_in_flight.pop_front() == OP_ALLOC && status == ST_OK) begin
          fresh.index      = result_index;
          fresh.generation = result_generation;
          fresh.stage      = HS_FRESH;
          pool.push_back(fresh);
          if (pool.size() > POOL_MAX) void'(pool.pop_front());
        end
      end
      if (in_valid && !in_stall) ops_in_flight.push_back(operation);
    end
  end

  task automatic issue(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] idx,
                       logic [HANDLE_W-1:0] hg);
    in_valid          <= 1'b1;
    operation         <= op;
    handle_index      <= idx;
    handle_generation <= hg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Sender gaps, drawn at random, only while bit 7 of the cycle counter is set
  task automatic sender_gap();
    if (!quiet && cyc[7] && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Hold the input until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned         pick;
    int unsigned         k;
    logic [HANDLE_W-1:0] idx;
    logic [HANDLE_W-1:0] hg;
    logic [OP_W-1:0]     op;
    pick = $urandom_range(0, 99);
    idx  = $urandom;
    hg   = $urandom;
    op   = OP_ALLOC;
    if (pick < 30 || (pool.size() == 0 && pick < 85)) begin
      op = OP_ALLOC;
    end else if (pick < 75) begin
      // next step in the life of a known handle
      k   = $urandom_range(0, pool.size() - 1);
      idx = pool[k].index;
      hg  = pool[k].generation;
      case (pool[k].stage)
        HS_FRESH: begin
          op            = OP_INIT;
          pool[k].stage = HS_READY;
        end
        HS_READY: begin
          if ($urandom_range(0, 9) < 6) begin
            op = OP_LOOK;
          end else begin
            op            = OP_FREE;
            pool[k].stage = HS_RETIRED;
          end
        end
        default: begin
          // stale use after free, then forget the handle
          op = ACCESS_OPS[$urandom_range(0, 2)];
          pool.delete(k);
        end
      endcase
    end else if (pick < 85) begin
      // known handle with one part disturbed
      k   = $urandom_range(0, pool.size() - 1);
      idx = pool[k].index;
      hg  = pool[k].generation;
      op  = ACCESS_OPS[$urandom_range(0, 2)];
      case ($urandom_range(0, 3))
        0:       hg = hg + 1;
        1:       hg = hg - 1;
        2:       hg[HANDLE_W-1] = 1'b1;
        default: idx = idx ^ (32'd1 << $urandom_range(0, HANDLE_W - 1));
      endcase
    end else if (pick < 93) begin
      // any slot, small generation; sometimes the null handle
      op  = ACCESS_OPS[$urandom_range(0, 2)];
      idx = $urandom_range(0, SLOTS - 1);
      hg  = $urandom_range(0, 64);
      if ($urandom_range(0, 5) == 0) begin
        idx = '0;
        hg  = '0;
      end
    end else begin
      op = OP_W'($urandom);
    end
    issue(op, idx, hg);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, first chunk, full life of one slot, tag corner cases
    issue(OP_LOOK, '0, '0);
    issue(OP_INIT, '0, '0);
    issue(OP_FREE, '0, '0);
    issue(OP_LOOK, 32'd5, 32'd1);
    issue(OP_ALLOC, TAG_FREE, TAG_FREE);
    issue(OP_LOOK, 32'd0, 32'd1);
    issue(OP_FREE, 32'd0, 32'd1);
    issue(OP_INIT, 32'd0, 32'd2);
    issue(OP_INIT, 32'd0, 32'd1);
    issue(OP_INIT, 32'd0, 32'd1);
    issue(OP_LOOK, 32'd0, 32'd1);
    issue(OP_LOOK, 32'd0, 32'h8000_0001);
    issue(OP_FREE, 32'd0, 32'd2);
    issue(OP_FREE, 32'd0, 32'd1);
    issue(OP_LOOK, 32'd0, 32'd1);
    issue(OP_INIT, 32'd0, 32'd1);
    issue(OP_LOOK, 32'd0, TAG_FREE);
    issue(OP_ALLOC, '0, '0);
    issue(OP_LOOK, 32'd1, 32'h8000_0002);
    issue(OP_LOOK, TAG_FREE, TAG_FREE);
    issue(OP_FREE, CHUNK, '0);
    issue(OP_LOOK, CHUNK - 1, '0);
    issue(OP_FREE, SLOTS, '0);
    drain();

    // Random mix of handle lifecycles, disturbed handles and noise
    repeat (500) begin
      sender_gap();
      random_item();
    end

    // Closing stretch without idling on either side
    quiet <= 1'b1;
    repeat (120) random_item();
    drain();
    repeat (80) @(posedge clk);

    $display("run: %0d transfers in, %0d results checked, %0d handles live at the end",
             n_sent, checked, live_total);
    $display("status codes returned, one bit per code: %b", seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_generation_checked_handle_allocator_unit OK");
    end else begin
      $display("tb_generation_checked_handle_allocator_unit NOT OK");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_generation_checked_handle_allocator_unit NOT OK");
    $finish;
  end

endmodule
